[hdl/two_link_inverse_kinematics_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the two-link inverse kinematics block.
// Each check can be compiled out by defining NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef TWO_LINK_INVERSE_KINEMATICS_ASSERT_SVH
`define TWO_LINK_INVERSE_KINEMATICS_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define TLIK_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TLIK_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`else
`define TLIK_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define TLIK_ASSERT_ALWAYS(label, clk, rst_n, expr, msg)
`endif
`endif

[hdl/tlik_pkg.sv]
// ----------------------------------------------------------------------------
// tlik_pkg
// Constants and tables shared by the two-link inverse kinematics block.
// ----------------------------------------------------------------------------
`default_nettype none
package tlik_pkg;
    localparam int AW = 48;
    typedef logic signed [AW-1:0] t_acc;
    localparam int TABLE_LEN = 24;
    localparam logic signed [AW-1:0] HALF_PI_Q = 48'sd102944;
    localparam logic [31:0] DEG_PER_RAD_Q = 32'd3754937;
    localparam logic signed [AW-1:0] Q_ONE = 48'sd65536;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_LINK1  = 2'd0,
        REG_LINK2  = 2'd1,
        REG_THRESH = 2'd2
    } t_reg_index;

    function automatic logic [15:0] atan_tab(input logic [4:0] i);
        logic [15:0] v;
        begin
            case (i)
                5'd0: v = 16'd51472;
                5'd1: v = 16'd30386;
                5'd2: v = 16'd16055;
                5'd3: v = 16'd8150;
                5'd4: v = 16'd4091;
                5'd5: v = 16'd2047;
                5'd6: v = 16'd1024;
                5'd7: v = 16'd512;
                5'd8: v = 16'd256;
                5'd9: v = 16'd128;
                5'd10: v = 16'd64;
                5'd11: v = 16'd32;
                5'd12: v = 16'd16;
                5'd13: v = 16'd8;
                5'd14: v = 16'd4;
                5'd15: v = 16'd2;
                5'd16: v = 16'd1;
                default: v = 16'd0;
            endcase
            return v;
        end
    endfunction
endpackage
`default_nettype wire

[hdl/tlik_if.sv]
// ----------------------------------------------------------------------------
// tlik_in_if / tlik_out_if
// Valid/ready channels that carry readings in and solutions out.
// ----------------------------------------------------------------------------
`default_nettype none
interface tlik_in_if;
    logic       valid;
    logic       ready;
    logic [9:0] base_pot;
    logic [9:0] elbow_pot;
    modport source (output valid, base_pot, elbow_pot, input ready);
    modport sink (input valid, base_pot, elbow_pot, output ready);
endinterface

interface tlik_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] target_x;
    logic [7:0] target_y;
    logic [7:0] base_angle;
    logic [7:0] elbow_angle;
    logic       base_update;
    logic       elbow_update;
    logic       reach_clamped;
    modport source (output valid, target_x, target_y, base_angle, elbow_angle,
                    base_update, elbow_update, reach_clamped, input ready);
    modport sink (input valid, target_x, target_y, base_angle, elbow_angle,
                  base_update, elbow_update, reach_clamped, output ready);
endinterface
`default_nettype wire

[hdl/two_link_inverse_kinematics.sv]
// ----------------------------------------------------------------------------
// two_link_inverse_kinematics
// Two-link planar arm solver built around sequential add/shift iterations.
// ----------------------------------------------------------------------------
// Flow from the input transfer to a valid result: two scaling multiplies, a 17-step divide,
// a 17-step square root and three CORDIC runs; a clamped ratio skips the divide steps.
// One pair is solved at a time; the next is taken the cycle after the result transfers.
// Reset is synchronous, active low; it restores register defaults and clears
// the previous targets.
`default_nettype none
`include "two_link_inverse_kinematics_assert.svh"
module two_link_inverse_kinematics #(
    parameter int ADC_MAX = 1023,
    parameter int CORDIC_STEPS = 16
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire [1:0]  i_cfg_index,
    input  wire [7:0]  i_cfg_data,
    tlik_in_if.sink    in_ch,
    tlik_out_if.source out_ch
);
    localparam int STEPS = (CORDIC_STEPS < tlik_pkg::TABLE_LEN) ? CORDIC_STEPS
                                                                : tlik_pkg::TABLE_LEN;
    localparam int SCALE_MAX = (ADC_MAX > 1023) ? 1023 : ADC_MAX;
    // Rounded-up 2^36 / ADC_MAX; exact floor for every pot * 180 below 2^18.
    localparam logic [28:0] SCALE_RECIP =
        29'(((64'd1 << 36) + 64'(ADC_MAX) - 64'd1) / 64'(ADC_MAX));

    typedef enum logic [3:0] {
        S_IDLE, S_SCALE, S_NUM, S_DIV, S_SQRT, S_CORD_INIT, S_CORD,
        S_CORD_DONE, S_DEG, S_DONE
    } t_state;

    t_state r_state;
    logic [7:0] r_l1, r_l2, r_th, r_px, r_py;
    logic [9:0] r_px_pot, r_py_pot;
    logic [7:0] r_tx, r_ty;
    logic [5:0] r_cnt;
    logic [1:0] r_sel;     // which atan2 or which target
    tlik_pkg::t_acc r_a, r_b, r_c, r_num, r_den, r_d, r_s;
    tlik_pkg::t_acc r_cx, r_cy, r_cz, r_elbow, r_base;
    logic r_neg, r_clamp;
    logic [7:0] r_bang, r_eang;
    logic r_oval, r_bu, r_eu;

    logic [7:0] l1, l2;
    assign l1 = (r_l1 == 8'd0) ? 8'd1 : r_l1;
    assign l2 = (r_l2 == 8'd0) ? 8'd1 : r_l2;

    logic [9:0] pot_sel;
    logic [17:0] pot_x180;
    logic [46:0] scale_prod;
    logic [7:0] scale_q;
    assign pot_sel = (r_sel == 2'd0) ? r_px_pot : r_py_pot;
    assign pot_x180 = {8'd0, pot_sel} * 18'd180;
    assign scale_prod = {29'd0, pot_x180} * {18'd0, SCALE_RECIP};
    assign scale_q = scale_prod[43:36];

    logic [15:0] tx_sq, ty_sq, l1_sq, l2_sq, l1_l2;
    assign tx_sq = {8'd0, r_tx} * {8'd0, r_tx};
    assign ty_sq = {8'd0, r_ty} * {8'd0, r_ty};
    assign l1_sq = {8'd0, l1} * {8'd0, l1};
    assign l2_sq = {8'd0, l2} * {8'd0, l2};
    assign l1_l2 = {8'd0, l1} * {8'd0, l2};

    // The ratio and the sine stay within 18 bits, so the products are narrow.
    logic signed [17:0] d_lo;
    logic signed [35:0] d_sq;
    logic signed [26:0] l2_d;
    logic [24:0] l2_s;
    assign d_lo = r_d[17:0];
    assign d_sq = d_lo * d_lo;
    assign l2_d = $signed({1'b0, l2}) * d_lo;
    assign l2_s = {17'd0, l2} * {8'd0, r_s[16:0]};

    // Shared shifter for CORDIC steps, arithmetic shift is floor.
    tlik_pkg::t_acc xs, ys, sub_r;
    assign xs = r_cx >>> r_cnt[4:0];
    assign ys = r_cy >>> r_cnt[4:0];
    assign sub_r = r_a - r_b;

    logic [7:0] deg_v;
    logic [55:0] prod;
    assign prod = {32'd0, r_c[23:0]} * {24'd0, tlik_pkg::DEG_PER_RAD_Q};
    always_comb begin
        if (r_c[tlik_pkg::AW-1] || r_c == '0) deg_v = 8'd0;
        else if (r_c[tlik_pkg::AW-2:24] != '0 || prod[55:32] > 24'd180) deg_v = 8'd180;
        else deg_v = prod[39:32];
    end

    assign in_ch.ready = (r_state == S_IDLE) && !r_oval;
    assign out_ch.valid = r_oval;
    assign out_ch.target_x = r_tx;
    assign out_ch.target_y = r_ty;
    assign out_ch.base_angle = r_bang;
    assign out_ch.elbow_angle = r_eang;
    assign out_ch.base_update = r_bu;
    assign out_ch.elbow_update = r_eu;
    assign out_ch.reach_clamped = r_clamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_l1 <= 8'd10; r_l2 <= 8'd10; r_th <= 8'd5;
            r_px <= '0; r_py <= '0; r_oval <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    tlik_pkg::REG_LINK1: r_l1 <= i_cfg_data;
                    tlik_pkg::REG_LINK2: r_l2 <= i_cfg_data;
                    tlik_pkg::REG_THRESH: r_th <= i_cfg_data;
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready) r_oval <= 1'b0;
            unique case (r_state)
                S_IDLE: if (in_ch.valid && in_ch.ready) begin
                    r_px_pot <= (32'(in_ch.base_pot) > 32'(SCALE_MAX)) ?
                                10'(SCALE_MAX) : in_ch.base_pot;
                    r_py_pot <= (32'(in_ch.elbow_pot) > 32'(SCALE_MAX)) ?
                                10'(SCALE_MAX) : in_ch.elbow_pot;
                    r_sel <= 2'd0;
                    r_state <= S_SCALE;
                    r_cnt <= '0;
                end
                S_SCALE: begin
                    // pot * 180 / ADC_MAX through the reciprocal, one target per cycle.
                    if (r_sel == 2'd0) begin
                        r_tx <= scale_q;
                        r_sel <= 2'd1;
                    end else begin
                        r_ty <= scale_q;
                        r_state <= S_NUM;
                    end
                end
                S_NUM: begin
                    r_num <= tlik_pkg::AW'(tx_sq) + tlik_pkg::AW'(ty_sq)
                             - tlik_pkg::AW'(l1_sq) - tlik_pkg::AW'(l2_sq);
                    r_den <= tlik_pkg::AW'({l1_l2, 1'b0});
                    r_cnt <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_cnt == 6'd0) begin
                        r_clamp <= (r_num > r_den) || (r_num < -r_den);
                        r_neg <= r_num[tlik_pkg::AW-1];
                        r_a <= (r_num[tlik_pkg::AW-1] ? -r_num : r_num) <<< 16;
                        r_c <= '0;
                        r_cnt <= 6'd1;
                    end else if (r_clamp) begin
                        r_d <= r_neg ? -tlik_pkg::Q_ONE : tlik_pkg::Q_ONE;
                        r_cnt <= '0;
                        r_state <= S_SQRT;
                    end else if (r_cnt == 6'd18) begin
                        r_d <= r_neg ? -r_c : r_c;
                        r_cnt <= '0;
                        r_state <= S_SQRT;
                    end else begin
                        // The quotient is at most 2^16, so 17 quotient bits suffice.
                        if (r_a >= (r_den <<< (17 - r_cnt))) begin
                            r_a <= r_a - (r_den <<< (17 - r_cnt));
                            r_c <= (r_c << 1) | tlik_pkg::t_acc'(1);
                        end else r_c <= r_c << 1;
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_SQRT: begin
                    // Digit-by-digit square root of 2^32 - d^2, r_a remainder.
                    if (r_cnt == 6'd0) begin
                        r_a <= (tlik_pkg::t_acc'(1) <<< 32) - tlik_pkg::AW'(d_sq);
                        r_s <= '0;
                        r_cnt <= 6'd1;
                    end else begin
                        if (r_a >= r_s + (tlik_pkg::t_acc'(1) <<< (2 * (17 - r_cnt)))) begin
                            r_a <= r_a - (r_s + (tlik_pkg::t_acc'(1) <<< (2 * (17 - r_cnt))));
                            r_s <= (r_s >>> 1) + (tlik_pkg::t_acc'(1) <<< (2 * (17 - r_cnt)));
                        end else r_s <= r_s >>> 1;
                        if (r_cnt == 6'd17) begin
                            r_sel <= 2'd0;
                            r_state <= S_CORD_INIT;
                        end else r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_CORD_INIT: begin
                    r_cnt <= '0;
                    unique case (r_sel)
                        2'd0: begin r_cx <= r_d; r_cy <= r_s; end
                        2'd1: begin
                            r_cx <= tlik_pkg::AW'(r_tx) <<< 16;
                            r_cy <= tlik_pkg::AW'(r_ty) <<< 16;
                        end
                        default: begin
                            r_cx <= (tlik_pkg::AW'(l1) <<< 16) + tlik_pkg::AW'(l2_d);
                            r_cy <= tlik_pkg::AW'(l2_s);
                        end
                    endcase
                    r_cz <= '0;
                    r_state <= S_CORD;
                end
                S_CORD: begin
                    if (r_cnt == 6'd0 && r_cx < 0) begin
                        // Quarter turn first; the steps then restart at index zero.
                        if (r_cy >= 0) begin
                            r_cx <= r_cy; r_cy <= -r_cx; r_cz <= tlik_pkg::HALF_PI_Q;
                        end else begin
                            r_cx <= -r_cy; r_cy <= r_cx; r_cz <= -tlik_pkg::HALF_PI_Q;
                        end
                        r_cnt <= 6'd32;
                    end else if (r_cnt == 6'd0 && r_cx == 0 && r_cy == 0) begin
                        r_state <= S_CORD_DONE;
                    end else begin
                        if (r_cy >= 0) begin
                            r_cx <= r_cx + ys; r_cy <= r_cy - xs;
                            r_cz <= r_cz + tlik_pkg::AW'(tlik_pkg::atan_tab(r_cnt[4:0]));
                        end else begin
                            r_cx <= r_cx - ys; r_cy <= r_cy + xs;
                            r_cz <= r_cz - tlik_pkg::AW'(tlik_pkg::atan_tab(r_cnt[4:0]));
                        end
                        if (r_cnt[4:0] == 5'(STEPS - 1)) r_state <= S_CORD_DONE;
                        r_cnt <= {1'b0, r_cnt[4:0] + 5'd1};
                    end
                end
                S_CORD_DONE: begin
                    unique case (r_sel)
                        2'd0: begin r_elbow <= r_cz; r_sel <= 2'd1; r_state <= S_CORD_INIT; end
                        2'd1: begin r_base <= r_cz; r_sel <= 2'd2; r_state <= S_CORD_INIT; end
                        default: begin
                            r_a <= r_base; r_b <= r_cz; r_state <= S_DEG; r_cnt <= '0;
                        end
                    endcase
                end
                S_DEG: begin
                    if (r_cnt == 6'd0) begin r_c <= sub_r; r_cnt <= 6'd1; end
                    else if (r_cnt == 6'd1) begin
                        r_bang <= deg_v; r_c <= r_elbow; r_cnt <= 6'd2;
                    end else begin
                        r_eang <= deg_v; r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_bu <= $signed({1'b0, r_tx}) - $signed({1'b0, r_px}) >
                            $signed({1'b0, r_th});
                    r_eu <= $signed({1'b0, r_ty}) - $signed({1'b0, r_py}) >
                            $signed({1'b0, r_th});
                    r_px <= r_tx; r_py <= r_ty;
                    r_oval <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `TLIK_ASSERT_IMPL(a_no_accept_busy, i_clk, i_rst_n,
        (r_state != S_IDLE) |-> !in_ch.ready, "input taken while busy")
    `TLIK_ASSERT_IMPL(a_done_valid, i_clk, i_rst_n,
        (r_state == S_DONE) |=> out_ch.valid, "result not presented")
    `TLIK_ASSERT_ALWAYS(a_angle_range, i_clk, i_rst_n,
        !out_ch.valid || (out_ch.base_angle <= 8'd180 && out_ch.elbow_angle <= 8'd180),
        "angle out of range")
endmodule
`default_nettype wire
